FILE: hw/rtl/grfai_pkg.sv
`default_nettype none

package grfai_pkg;

  // field widths
  localparam int unsigned RawW    = 16;
  localparam int unsigned BiasW   = 16;
  localparam int unsigned GainW   = 13;
  localparam int unsigned DbandW  = 29;
  localparam int unsigned TstepW  = 16;
  localparam int unsigned RateW   = 30;
  localparam int unsigned AngleW  = 40;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 29;

  localparam int unsigned WindowDefault = 10;

  // dividend bits fed to the reciprocal multiplier per divide step
  localparam int unsigned DigitBits = 18;

  // configuration reset values
  localparam logic signed [BiasW-1:0] BiasReset  = '0;
  localparam logic [GainW-1:0]        GainReset  = 13'd4000;
  localparam logic [DbandW-1:0]       DbandReset = 29'd196608;
  localparam logic [TstepW-1:0]       TstepReset = 16'd655;

  // heading constants, Q16 degrees
  localparam logic signed [AngleW-1:0] HeadingReset = 40'sd5898240;
  localparam logic signed [AngleW+1:0] Deg360       = 42'sd23592960;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RATE_BIAS = 2'd0,
    CFG_RATE_GAIN = 2'd1,
    CFG_DEADBAND  = 2'd2,
    CFG_TIME_STEP = 2'd3
  } cfg_idx_e;

  // microcode
  localparam int unsigned StepW = 4;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SCALE,
    OP_DEADBAND,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SIGN,
    OP_INTEG,
    OP_SUB,
    OP_WRAP
  } op_e;

  typedef enum logic [1:0] {
    C_NEXT,     // advance
    C_HOLD_IN,  // hold until an input word is taken
    C_LOOP,     // jump to target until the divide is done
    C_RET       // hold while the output is full, then jump to target
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [StepW-1:0] step);
    uword_t w;
    w = '{op: OP_IDLE, cond: C_HOLD_IN, target: '0};
    unique case (step)
      4'd0:    w = '{op: OP_IDLE,     cond: C_HOLD_IN, target: 4'd0};
      4'd1:    w = '{op: OP_SCALE,    cond: C_NEXT,    target: 4'd0};
      4'd2:    w = '{op: OP_DEADBAND, cond: C_NEXT,    target: 4'd0};
      4'd3:    w = '{op: OP_ACCUM,    cond: C_NEXT,    target: 4'd0};
      4'd4:    w = '{op: OP_DIV_INIT, cond: C_NEXT,    target: 4'd0};
      4'd5:    w = '{op: OP_DIV_STEP, cond: C_LOOP,    target: 4'd5};
      4'd6:    w = '{op: OP_SIGN,     cond: C_NEXT,    target: 4'd0};
      4'd7:    w = '{op: OP_INTEG,    cond: C_NEXT,    target: 4'd0};
      4'd8:    w = '{op: OP_SUB,      cond: C_NEXT,    target: 4'd0};
      4'd9:    w = '{op: OP_WRAP,     cond: C_RET,     target: 4'd0};
      default: w = '{op: OP_IDLE,     cond: C_HOLD_IN, target: 4'd0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gyro_rate_filter_angle_integrator_core.sv
`default_nettype none

// Channel | Signals                                        | Direction
// --------+------------------------------------------------+----------
// in      | in_valid_i, in_ready_o, raw_rate_i             | sink
// out     | out_valid_o, out_ready_i, filtered_rate_o,     | source
//         | angle_o                                        |
// cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i               | sink
//
// A word passes the scale, deadband, accumulate, divide, sign, integrate, subtract and wrap
// steps to the result register; the divide is a two-step reciprocal multiply at WINDOW = 10.
// in_ready_o is high only in the idle step, so the next word is taken only after the wrap step.
// The result register holds a finished word while the next one is accepted;
// the last step stalls only if that register is still full.
// Reset clears fill flag, sum, slot, step, divide count, out_valid_o; presets heading, config.
module gyro_rate_filter_angle_integrator_core #(
  parameter int unsigned WINDOW = grfai_pkg::WindowDefault
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic signed [grfai_pkg::RawW-1:0]      raw_rate_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed [grfai_pkg::RateW-1:0]          filtered_rate_o,
  output logic signed [grfai_pkg::AngleW-1:0]         angle_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic [grfai_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  wire logic [grfai_pkg::CfgW-1:0]             cfg_wdata_i
);

  localparam int unsigned RateW     = grfai_pkg::RateW;
  localparam int unsigned AngleW    = grfai_pkg::AngleW;
  localparam int unsigned SlotW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SumW      = RateW + $clog2(WINDOW);
  localparam int unsigned DivSteps  = (SumW + grfai_pkg::DigitBits - 1) / grfai_pkg::DigitBits;
  localparam int unsigned DivW      = DivSteps * grfai_pkg::DigitBits;
  localparam int unsigned DivCntW   = (DivSteps > 1) ? $clog2(DivSteps) : 1;
  // floor(x / WINDOW) equals (x * Recip) >> RecipShift for every x below 2^SumW
  localparam int unsigned RecipShift = SumW + $clog2(WINDOW);
  localparam int unsigned RecipW    = SumW + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int unsigned PartW     = grfai_pkg::DigitBits + RecipW;
  localparam int unsigned AccW      = DivW + RecipW;
  localparam int unsigned ScaleW    = grfai_pkg::RawW + 1 + grfai_pkg::GainW + 1;
  localparam int unsigned ProdW     = RateW + grfai_pkg::TstepW + 1;
  localparam int unsigned TW        = AngleW + 2;

  // configuration registers
  logic signed [grfai_pkg::BiasW-1:0] bias_q;
  logic [grfai_pkg::GainW-1:0]        gain_q;
  logic [grfai_pkg::DbandW-1:0]       dband_q;
  logic [grfai_pkg::TstepW-1:0]       tstep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q  <= grfai_pkg::BiasReset;
      gain_q  <= grfai_pkg::GainReset;
      dband_q <= grfai_pkg::DbandReset;
      tstep_q <= grfai_pkg::TstepReset;
    end else if (cfg_we_i) begin
      unique case (grfai_pkg::cfg_idx_e'(cfg_idx_i))
        grfai_pkg::CFG_RATE_BIAS: bias_q  <= cfg_wdata_i[grfai_pkg::BiasW-1:0];
        grfai_pkg::CFG_RATE_GAIN: gain_q  <= cfg_wdata_i[grfai_pkg::GainW-1:0];
        grfai_pkg::CFG_DEADBAND:  dband_q <= cfg_wdata_i[grfai_pkg::DbandW-1:0];
        grfai_pkg::CFG_TIME_STEP: tstep_q <= cfg_wdata_i[grfai_pkg::TstepW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic [grfai_pkg::StepW-1:0] step_q, step_d;
  grfai_pkg::uword_t           uw;
  logic                        in_fire;
  logic                        out_free;
  logic                        div_last;
  logic [DivCntW-1:0]          div_cnt_q, div_cnt_d;

  assign uw       = grfai_pkg::ucode(step_q);
  assign in_ready_o = (uw.op == grfai_pkg::OP_IDLE);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_o || out_ready_i;
  assign div_last = (div_cnt_q == DivCntW'(DivSteps - 1));

  always_comb begin
    step_d = step_q;
    unique case (uw.cond)
      grfai_pkg::C_NEXT:    step_d = step_q + 1'b1;
      grfai_pkg::C_HOLD_IN: if (in_fire) step_d = step_q + 1'b1;
      grfai_pkg::C_LOOP:    step_d = div_last ? step_q + 1'b1 : uw.target;
      grfai_pkg::C_RET:     if (out_free) step_d = uw.target;
      default:              step_d = '0;
    endcase
  end

  always_comb begin
    div_cnt_d = div_cnt_q;
    if (uw.op == grfai_pkg::OP_DIV_INIT) begin
      div_cnt_d = '0;
    end else if (uw.op == grfai_pkg::OP_DIV_STEP) begin
      div_cnt_d = div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      div_cnt_q <= '0;
    end else begin
      step_q    <= step_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // datapath
  logic signed [grfai_pkg::RawW-1:0] raw_q;
  logic signed [ScaleW-1:0]          scale_full;
  logic signed [RateW-1:0]           rate_q;
  logic [RateW-1:0]                  rate_mag;
  logic signed [RateW-1:0]           rate_db_q;
  logic signed [RateW-1:0]           old_q;
  logic signed [RateW-1:0]           old_eff;
  logic signed [RateW-1:0]           win_mem [WINDOW];
  logic [SlotW-1:0]                  slot_q;
  logic                              filled_q;
  logic signed [SumW-1:0]            sum_q, sum_d;
  logic [DivW-1:0]                   dq_q, dq_d;
  logic [AccW-1:0]                   acc_q, acc_d;
  logic [PartW-1:0]                  div_part;
  logic                              neg_q;
  logic [SumW-1:0]                   sum_mag;
  logic [RateW-1:0]                  quot;
  logic signed [RateW-1:0]           avg_q;
  logic signed [ProdW-1:0]           prod_q;
  logic signed [TW-1:0]              t_q;
  logic signed [TW-1:0]              t_wrap;
  logic signed [AngleW-1:0]          heading_q;
  logic                              wrap_fire;

  assign scale_full = ScaleW'($signed({raw_q[grfai_pkg::RawW-1], raw_q})
                              - $signed({bias_q[grfai_pkg::BiasW-1], bias_q}))
                      * $signed({1'b0, gain_q});
  assign rate_mag   = rate_q[RateW-1] ? RateW'(-rate_q) : RateW'(rate_q);
  assign old_eff    = filled_q ? old_q : '0;
  assign sum_d      = sum_q - SumW'(old_eff) + SumW'(rate_db_q);
  assign sum_mag    = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign div_part   = PartW'(dq_q[DivW-1 -: grfai_pkg::DigitBits]) * PartW'(Recip);
  assign quot       = acc_q[RecipShift +: RateW];
  assign wrap_fire  = (uw.op == grfai_pkg::OP_WRAP) && out_free;

  // fold the top dividend chunk times the reciprocal into the product, top chunk first
  always_comb begin
    dq_d  = dq_q << grfai_pkg::DigitBits;
    acc_d = (acc_q << grfai_pkg::DigitBits) + AccW'(div_part);
  end

  always_comb begin
    t_wrap = t_q;
    if (t_q >= grfai_pkg::Deg360) begin
      t_wrap = t_q - grfai_pkg::Deg360;
    end else if (t_q <= -grfai_pkg::Deg360) begin
      t_wrap = t_q + grfai_pkg::Deg360;
    end
  end

  // window store: read the current slot every cycle, write it on accumulate
  always_ff @(posedge clk_i) begin
    if (uw.op == grfai_pkg::OP_ACCUM) begin
      win_mem[slot_q] <= rate_db_q;
    end
    old_q <= win_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q <= raw_rate_i;
    end
    if (uw.op == grfai_pkg::OP_SCALE) begin
      rate_q <= scale_full[RateW-1:0];
    end
    if (uw.op == grfai_pkg::OP_DEADBAND) begin
      rate_db_q <= (rate_mag < {1'b0, dband_q}) ? '0 : rate_q;
    end
    if (uw.op == grfai_pkg::OP_DIV_INIT) begin
      dq_q  <= DivW'(sum_mag);
      acc_q <= '0;
      neg_q <= sum_q[SumW-1];
    end else if (uw.op == grfai_pkg::OP_DIV_STEP) begin
      dq_q  <= dq_d;
      acc_q <= acc_d;
    end
    if (uw.op == grfai_pkg::OP_SIGN) begin
      avg_q <= neg_q ? RateW'(-quot) : RateW'(quot);
    end
    if (uw.op == grfai_pkg::OP_INTEG) begin
      prod_q <= avg_q * $signed({1'b0, tstep_q});
    end
    if (uw.op == grfai_pkg::OP_SUB) begin
      // arithmetic shift floors the Q16 product
      t_q <= TW'(heading_q) - TW'($signed(prod_q[ProdW-1:16]));
    end
    if (wrap_fire) begin
      filtered_rate_o <= avg_q;
      angle_o         <= t_wrap[AngleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      filled_q    <= 1'b0;
      sum_q       <= '0;
      heading_q   <= grfai_pkg::HeadingReset;
      out_valid_o <= 1'b0;
    end else begin
      if (uw.op == grfai_pkg::OP_ACCUM) begin
        sum_q <= sum_d;
        if (slot_q == SlotW'(WINDOW - 1)) begin
          slot_q   <= '0;
          filled_q <= 1'b1;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
      if (wrap_fire) begin
        heading_q   <= t_wrap[AngleW-1:0];
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import grfai_pkg::*;

  localparam int Window     = WindowDefault;
  localparam int SettleGap  = 25;
  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int BlockWords = 100;
  localparam int DriftWords = 1150;
  localparam int SenderIdle [4]   = '{0, 61, 0, 32};
  localparam int ReceiverStall [4] = '{0, 0, 61, 32};

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [CfgW-1:0]   value;
    logic              typed;
    logic [RateW-1:0]  rate;
    logic [AngleW-1:0] angle;
  } drill_row_t;

  typedef struct packed {
    logic [RateW-1:0]  rate;
    logic [AngleW-1:0] angle;
  } rate_angle_t;

  localparam drill_row_t DrillRows [28] = '{
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h0000,      1'b1, 30'd0, HeadingReset},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h0000,      1'b1, 30'd0, HeadingReset},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h7FFF,      1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h8000,      1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h0001,      1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'hFFFF,      1'b0, 30'd0, 40'd0},
    // deadband edge: 49 counts at gain 4096 lands exactly on the threshold
    '{ROW_WRITE,  CFG_RATE_GAIN, 29'd4096,      1'b0, 30'd0, 40'd0},
    '{ROW_WRITE,  CFG_DEADBAND,  29'd200704,    1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'd49,        1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'd48,        1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'hFFCF,      1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'hFFD0,      1'b0, 30'd0, 40'd0},
    // upper write bits must be dropped
    '{ROW_WRITE,  CFG_RATE_BIAS, 29'h1FFF8000,  1'b0, 30'd0, 40'd0},
    '{ROW_WRITE,  CFG_RATE_GAIN, 29'h1FFFFFFF,  1'b0, 30'd0, 40'd0},
    '{ROW_WRITE,  CFG_DEADBAND,  29'd0,         1'b0, 30'd0, 40'd0},
    '{ROW_WRITE,  CFG_TIME_STEP, 29'h1FFFFFFF,  1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h7FFF,      1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h7FFF,      1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h8000,      1'b0, 30'd0, 40'd0},
    '{ROW_WRITE,  CFG_DEADBAND,  29'd536797185, 1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h7FFF,      1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h7FFE,      1'b0, 30'd0, 40'd0},
    '{ROW_WRITE,  CFG_RATE_BIAS, 29'h7FFF,      1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h8000,      1'b0, 30'd0, 40'd0},
    '{ROW_WRITE,  CFG_TIME_STEP, 29'd0,         1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'd12345,     1'b0, 30'd0, 40'd0},
    '{ROW_WRITE,  CFG_RATE_GAIN, 29'd0,         1'b0, 30'd0, 40'd0},
    '{ROW_SAMPLE, CFG_RATE_BIAS, 29'h8000,      1'b0, 30'd0, 40'd0}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [RawW-1:0]   raw_rate_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [RateW-1:0]  filtered_rate_o;
  logic signed [AngleW-1:0] angle_o;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [CfgW-1:0]          cfg_wdata_i;

  // predictor copy of the registers and the filter state
  logic signed [BiasW-1:0]  bias_q;
  logic [GainW-1:0]         gain_q;
  logic [DbandW-1:0]        dband_q;
  logic [TstepW-1:0]        tstep_q;
  longint                   rate_win [Window];
  longint                   win_sum;
  int                       win_slot;
  logic signed [AngleW-1:0] heading_q;

  rate_angle_t due_rate_angle [$];

  int in_idle_pct;
  int out_stall_pct;
  int hold_requests;
  int samples_sent;
  int results_seen;
  int reg_writes;
  int mismatches;
  int quiet_cycles;

  always #5 clk_i = ~clk_i;

  gyro_rate_filter_angle_integrator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .raw_rate_i      (raw_rate_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .filtered_rate_o (filtered_rate_o),
    .angle_o         (angle_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  function automatic rate_angle_t integrate_sample(input logic signed [RawW-1:0] raw);
    longint      rate;
    longint      mag;
    longint      avg;
    longint      t;
    rate_angle_t r;
    rate = (longint'(raw) - longint'(bias_q)) * longint'(gain_q);
    mag = (rate < 0) ? -rate : rate;
    if (mag < longint'(dband_q)) begin
      rate = 0;
    end
    win_sum = win_sum - rate_win[win_slot] + rate;
    rate_win[win_slot] = rate;
    win_slot = (win_slot == Window - 1) ? 0 : win_slot + 1;
    avg = win_sum / Window;
    // arithmetic shift floors toward minus infinity
    t = longint'(heading_q) - ((avg * longint'(tstep_q)) >>> 16);
    if (t >= longint'(Deg360)) begin
      t = t - longint'(Deg360);
    end else if (t <= -longint'(Deg360)) begin
      t = t + longint'(Deg360);
    end
    heading_q = t[AngleW-1:0];
    r.rate = avg[RateW-1:0];
    r.angle = heading_q;
    return r;
  endfunction

  function automatic logic signed [RawW-1:0] pick_raw();
    int         sel;
    logic [RawW-1:0] off;
    sel = $urandom_range(9);
    off = RawW'($urandom_range(127)) - RawW'(64);
    if (sel < 4) return bias_q + off;
    if (sel == 4) return 16'sh7FFF;
    if (sel == 5) return 16'sh8000;
    if (sel == 6) return '0;
    return RawW'($urandom);
  endfunction

  function automatic logic [CfgW-1:0] pick_reg(input cfg_idx_e idx);
    int sel;
    sel = $urandom_range(3);
    case (idx)
      CFG_RATE_BIAS: begin
        return (sel == 0) ? 29'h0 : (sel == 1) ? 29'h8000 : (sel == 2) ? 29'h7FFF
                                                                       : CfgW'($urandom);
      end
      CFG_RATE_GAIN: begin
        return (sel == 0) ? 29'd0 : (sel == 1) ? 29'd8191 : (sel == 2) ? 29'd4000
                                                                       : CfgW'($urandom);
      end
      CFG_DEADBAND: begin
        return (sel == 0) ? 29'd0 : (sel == 1) ? 29'd536797185
             : (sel == 2) ? CfgW'($urandom_range(1 << 22)) : CfgW'($urandom_range(536797185));
      end
      default: begin
        return (sel == 0) ? 29'd0 : (sel == 1) ? 29'd65535 : (sel == 2) ? 29'd655
                                                                        : CfgW'($urandom);
      end
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RATE_BIAS: bias_q = value[BiasW-1:0];
      CFG_RATE_GAIN: gain_q = value[GainW-1:0];
      CFG_DEADBAND:  dband_q = value[DbandW-1:0];
      default:       tstep_q = value[TstepW-1:0];
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  // drain every pending result, then let the sequencer return to idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_rate_angle.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic reconfigure();
    settle();
    write_reg(CFG_RATE_BIAS, pick_reg(CFG_RATE_BIAS));
    write_reg(CFG_RATE_GAIN, pick_reg(CFG_RATE_GAIN));
    write_reg(CFG_DEADBAND, pick_reg(CFG_DEADBAND));
    write_reg(CFG_TIME_STEP, pick_reg(CFG_TIME_STEP));
  endtask

  task automatic send_word(input logic signed [RawW-1:0] raw, input logic typed,
                           input rate_angle_t given);
    rate_angle_t r;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_rate_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = integrate_sample(raw);
    if (typed) begin
      r = given;
    end
    due_rate_angle.push_back(r);
    samples_sent++;
  endtask

  // output side: check each word, then decide ready for the next edge
  initial begin : rx
    int          hold_left;
    int          holds_served;
    rate_angle_t want;
    hold_left = 0;
    holds_served = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (due_rate_angle.size() == 0) begin
          $display("%0t: unexpected word rate=%0d angle=%0d", $time, filtered_rate_o, angle_o);
          mismatches++;
        end else begin
          want = due_rate_angle.pop_front();
          if (filtered_rate_o !== want.rate) begin
            $display("%0t: filtered_rate expected %0d got %0d", $time,
                     $signed(want.rate), filtered_rate_o);
            mismatches++;
          end
          if (angle_o !== want.angle) begin
            $display("%0t: angle expected %0d got %0d", $time, $signed(want.angle), angle_o);
            mismatches++;
          end
          results_seen++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim
    rate_angle_t given;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    raw_rate_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_RATE_BIAS;
    cfg_wdata_i = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_requests = 0;
    samples_sent = 0;
    results_seen = 0;
    reg_writes = 0;
    mismatches = 0;
    bias_q = BiasReset;
    gain_q = GainReset;
    dband_q = DbandReset;
    tstep_q = TstepReset;
    foreach (rate_win[i]) rate_win[i] = 0;
    win_sum = 0;
    win_slot = 0;
    heading_q = HeadingReset;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DrillRows[i]) begin
      if (DrillRows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(DrillRows[i].idx, DrillRows[i].value);
      end else begin
        given.rate = DrillRows[i].rate;
        given.angle = DrillRows[i].angle;
        send_word(DrillRows[i].value[RawW-1:0], DrillRows[i].typed, given);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = SenderIdle[ph];
      out_stall_pct = ReceiverStall[ph];
      for (int blk = 0; blk < 2; blk++) begin
        reconfigure();
        // long output hold-off: fill the block and back up the input
        if (ph == 0 && blk == 0) hold_requests++;
        repeat (BlockWords) send_word(pick_raw(), 1'b0, '0);
      end
    end

    // full-scale drift: run the heading past the 40-bit range
    settle();
    in_idle_pct = 0;
    out_stall_pct = 0;
    write_reg(CFG_RATE_BIAS, 29'h8000);
    write_reg(CFG_RATE_GAIN, 29'd8191);
    write_reg(CFG_DEADBAND, 29'd0);
    write_reg(CFG_TIME_STEP, 29'd65535);
    repeat (DriftWords) send_word(16'sh7FFF - RawW'($urandom_range(7)), 1'b0, '0);

    settle();
    $display("Covered %0d samples and %0d checked words across %0d register writes,",
             samples_sent, results_seen, reg_writes);
    $display("with idle/stall mixes, a long output hold-off and a full-scale heading drift.");
    if (mismatches == 0 && due_rate_angle.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
